// ===== rtl/midi_track_event_encoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// MIDI track event encoder: assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_ENCODER_CORE_ASSERT_SVH
`define MIDI_TRACK_EVENT_ENCODER_CORE_ASSERT_SVH

// same-cycle implication
`define MTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("mte assertion failed");

// next-cycle implication
`define MTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("mte assertion failed");

`endif

// ===== rtl/mte_pkg.sv =====
// ----------------------------------------------------------------------------
// mte_pkg
// Shared constants and types of the MIDI track event encoder.
// ----------------------------------------------------------------------------
package mte_pkg;

    localparam int TIME_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int TPS_W      = 15;               // ticks per second up to 32767
    localparam int PROD_W     = TIME_W + TPS_W;
    localparam int DELTA_W    = 28;               // four VLQ groups
    localparam int GROUP_W    = 7;
    localparam int MAX_BYTES  = 7;
    localparam int CNT_W      = 3;
    localparam int TICKS_PER_SECOND_DEF = 480;

    localparam logic FUNC_NOTE = 1'b0;
    localparam logic FUNC_EOT  = 1'b1;

    localparam logic KIND_OFF = 1'b0;
    localparam logic KIND_ON  = 1'b1;

    localparam logic [3:0] STATUS_NOTE_ON_HI  = 4'h9;
    localparam logic [3:0] STATUS_NOTE_OFF_HI = 4'h8;

    localparam logic [7:0] EOT_DELTA  = 8'h00;
    localparam logic [7:0] EOT_META   = 8'hFF;
    localparam logic [7:0] EOT_TYPE   = 8'h2F;
    localparam logic [7:0] EOT_LENGTH = 8'h00;

    localparam logic [CNT_W-1:0] EOT_BYTES = 3'd4;

    typedef struct packed {
        logic       func;
        logic       kind;
        logic [3:0] chan;
        logic [6:0] note;
        logic [6:0] vel;
    } t_evt;

    typedef struct packed {
        t_evt              evt;
        logic [PROD_W-1:0] product;
    } t_mul_req;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;   // bytes[0] goes out first
        logic [CNT_W-1:0]          count;
    } t_ser_load;

endpackage

// ===== rtl/midi_track_event_encoder_core.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_encoder_core
// Note events and end-of-track requests in, MIDI track byte stream out.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one request per handshake, a note event
// with its time stamp or an end-of-track marker. Output channel
// (o_valid/i_ready): one track byte per handshake, o_last_byte marks the
// final byte of a request.
// Config: i_cfg_we writes i_cfg_wdata into the record enable; note events
// are dropped without output while it is clear. End of track always emits.
// Path: an accepted request goes through the input register and the
// multiply register, then the shifter load presents its first byte.
// Throughput: one output byte per cycle while i_ready is high; a note is
// 4 to 7 bytes (1 to 4 delta bytes plus status, note, velocity), end of
// track 4 bytes; a dropped note gives no bytes. The output shifter sets the
// pace; the next request loads as the last byte of the previous one leaves.
// Reset: clears the record enable, the previous time and all valid flags.
// Stall: while i_ready is low the output byte holds; the two front stages
// fill and then o_ready drops.
// ----------------------------------------------------------------------------
module midi_track_event_encoder_core
    import mte_pkg::*;
#(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [TIME_W-1:0] i_event_time,
    input  logic              i_note_kind,
    input  logic [3:0]        i_midi_channel,
    input  logic [6:0]        i_note_number,
    input  logic [6:0]        i_note_velocity,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_last_byte
);

    t_evt      evt;
    t_mul_req  mul_req;
    t_ser_load ser_load;
    logic      mul_valid;
    logic      mul_ready;

    assign evt.func = i_func;
    assign evt.kind = i_note_kind;
    assign evt.chan = i_midi_channel;
    assign evt.note = i_note_number;
    assign evt.vel  = i_note_velocity;

    mte_front #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_evt        (evt),
        .i_event_time (i_event_time),
        .o_valid      (mul_valid),
        .i_ready      (mul_ready),
        .o_req        (mul_req)
    );

    mte_pack u_pack (
        .i_req  (mul_req),
        .o_load (ser_load)
    );

    mte_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (mul_valid),
        .o_load_ready (mul_ready),
        .i_load       (ser_load),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule

// ===== rtl/mte_front.sv =====
// ----------------------------------------------------------------------------
// mte_front
// Input register, previous-time state, clamped delta and tick multiply.
// ----------------------------------------------------------------------------
module mte_front
    import mte_pkg::*;
#(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_evt              i_evt,
    input  logic [TIME_W-1:0] i_event_time,
    output logic              o_valid,
    input  logic              i_ready,
    output t_mul_req          o_req
);

    localparam logic [TPS_W-1:0] TPS_VAL = TPS_W'(TICKS_PER_SECOND);

    logic              r_rec_en;
    logic [TIME_W-1:0] r_prev_time;
    logic              r_s1_valid;
    t_evt              r_s1_evt;
    logic [TIME_W-1:0] r_s1_diff;
    logic              r_s2_valid;
    t_evt              r_s2_evt;
    logic [PROD_W-1:0] r_s2_prod;

    logic              accept;
    logic              drop;
    logic              s2_take;
    logic              s1_move;
    logic [TIME_W:0]   sub;
    logic [TIME_W-1:0] n_s1_diff;
    logic [TIME_W-1:0] n_prev_time;
    logic [PROD_W-1:0] n_s2_prod;

    assign s2_take = !r_s2_valid || i_ready;
    assign s1_move = r_s1_valid && s2_take;
    assign o_ready = !r_s1_valid || s2_take;
    assign accept  = i_valid && o_ready;
    assign drop    = (i_evt.func == FUNC_NOTE) && !r_rec_en;

    // borrow out means time went backwards: clamp to zero
    assign sub       = {1'b0, i_event_time} - {1'b0, r_prev_time};
    assign n_s1_diff = sub[TIME_W] ? '0 : sub[TIME_W-1:0];

    always_comb begin
        n_prev_time = r_prev_time;
        if (accept) begin
            if (i_evt.func == FUNC_EOT) begin
                n_prev_time = '0;
            end else if (r_rec_en) begin
                n_prev_time = i_event_time;
            end
        end
    end

    assign n_s2_prod = {{TPS_W{1'b0}}, r_s1_diff} * {{TIME_W{1'b0}}, TPS_VAL};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_en    <= 1'b0;
            r_prev_time <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rec_en <= i_cfg_wdata;
            end
            r_prev_time <= n_prev_time;
            if (accept) begin
                r_s1_valid <= !drop;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_take) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_evt  <= i_evt;
            r_s1_diff <= n_s1_diff;
        end
        if (s1_move) begin
            r_s2_evt  <= r_s1_evt;
            r_s2_prod <= n_s2_prod;
        end
    end

    assign o_valid       = r_s2_valid;
    assign o_req.evt     = r_s2_evt;
    assign o_req.product = r_s2_prod;

`include "midi_track_event_encoder_core_assert.svh"

    `MTE_ASSERT_NEXT(a_eot_clears_time, accept && (i_evt.func == FUNC_EOT), r_prev_time == '0)
    `MTE_ASSERT_NEXT(a_drop_keeps_state, accept && drop, !r_s1_valid && $stable(r_prev_time))
    `MTE_ASSERT_NEXT(a_s2_holds_on_stall, r_s2_valid && !i_ready, r_s2_valid)

endmodule

// ===== rtl/mte_pack.sv =====
// ----------------------------------------------------------------------------
// mte_pack
// Tick saturation, VLQ split and byte list assembly for one request.
// ----------------------------------------------------------------------------
module mte_pack
    import mte_pkg::*;
(
    input  t_mul_req  i_req,
    output t_ser_load o_load
);

    logic                 sat;
    logic [DELTA_W-1:0]   ticks;
    logic [GROUP_W-1:0]   g0;
    logic [GROUP_W-1:0]   g1;
    logic [GROUP_W-1:0]   g2;
    logic [GROUP_W-1:0]   g3;
    logic [1:0]           top_group;
    logic [7:0]           status;
    logic [7:0]           note_b;
    logic [7:0]           vel_b;

    // product >> FRAC_W above DELTA_W bits saturates
    assign sat   = |i_req.product[PROD_W-1:FRAC_W+DELTA_W];
    assign ticks = sat ? '1 : i_req.product[FRAC_W+DELTA_W-1:FRAC_W];

    assign g0 = ticks[6:0];
    assign g1 = ticks[13:7];
    assign g2 = ticks[20:14];
    assign g3 = ticks[27:21];

    always_comb begin
        if (g3 != '0) begin
            top_group = 2'd3;
        end else if (g2 != '0) begin
            top_group = 2'd2;
        end else if (g1 != '0) begin
            top_group = 2'd1;
        end else begin
            top_group = 2'd0;
        end
    end

    assign status = {(i_req.evt.kind == KIND_ON) ? STATUS_NOTE_ON_HI : STATUS_NOTE_OFF_HI,
                     i_req.evt.chan};
    assign note_b = {1'b0, i_req.evt.note};
    assign vel_b  = (i_req.evt.kind == KIND_ON) ? {1'b0, i_req.evt.vel} : 8'h00;

    always_comb begin
        o_load.bytes = '0;
        o_load.count = EOT_BYTES;
        if (i_req.evt.func == FUNC_EOT) begin
            o_load.bytes[0] = EOT_DELTA;
            o_load.bytes[1] = EOT_META;
            o_load.bytes[2] = EOT_TYPE;
            o_load.bytes[3] = EOT_LENGTH;
        end else begin
            case (top_group)
                2'd3: begin
                    o_load.bytes[0] = {1'b1, g3};
                    o_load.bytes[1] = {1'b1, g2};
                    o_load.bytes[2] = {1'b1, g1};
                    o_load.bytes[3] = {1'b0, g0};
                    o_load.bytes[4] = status;
                    o_load.bytes[5] = note_b;
                    o_load.bytes[6] = vel_b;
                    o_load.count    = 3'd7;
                end
                2'd2: begin
                    o_load.bytes[0] = {1'b1, g2};
                    o_load.bytes[1] = {1'b1, g1};
                    o_load.bytes[2] = {1'b0, g0};
                    o_load.bytes[3] = status;
                    o_load.bytes[4] = note_b;
                    o_load.bytes[5] = vel_b;
                    o_load.count    = 3'd6;
                end
                2'd1: begin
                    o_load.bytes[0] = {1'b1, g1};
                    o_load.bytes[1] = {1'b0, g0};
                    o_load.bytes[2] = status;
                    o_load.bytes[3] = note_b;
                    o_load.bytes[4] = vel_b;
                    o_load.count    = 3'd5;
                end
                default: begin
                    o_load.bytes[0] = {1'b0, g0};
                    o_load.bytes[1] = status;
                    o_load.bytes[2] = note_b;
                    o_load.bytes[3] = vel_b;
                    o_load.count    = 3'd4;
                end
            endcase
        end
    end

endmodule

// ===== rtl/mte_ser.sv =====
// ----------------------------------------------------------------------------
// mte_ser
// Output byte shifter: sends a loaded byte list one byte per request.
// ----------------------------------------------------------------------------
module mte_ser
    import mte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load_valid,
    output logic       o_load_ready,
    input  t_ser_load  i_load,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte
);

    logic                      r_valid;
    logic [CNT_W-1:0]          r_left;
    logic [MAX_BYTES-1:0][7:0] r_bytes;

    logic send;
    logic load;

    assign send         = r_valid && i_ready;
    assign o_last_byte  = (r_left == CNT_W'(1));
    // next list loads as the last byte of the current one leaves
    assign o_load_ready = !r_valid || (i_ready && o_last_byte);
    assign load         = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_left  <= i_load.count;
            end else if (send) begin
                r_valid <= !o_last_byte;
                r_left  <= r_left - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= i_load.bytes;
        end else if (send) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_bytes[0];

`include "midi_track_event_encoder_core_assert.svh"

    `MTE_ASSERT_NOW(a_left_in_range, r_valid, (r_left != '0) && (r_left <= CNT_W'(MAX_BYTES)))
    `MTE_ASSERT_NOW(a_load_count, load, (i_load.count >= EOT_BYTES) && (i_load.count <= CNT_W'(MAX_BYTES)))
    `MTE_ASSERT_NEXT(a_item_continues, send && !o_last_byte, r_valid)

endmodule
